// File: hw/rtl/rgbpwm_pkg.sv
// Shared types and constants of the RGB soft PWM with fade block.
package rgbpwm_pkg;

    // Width of a level, a target, a step size and the period counter.
    localparam int LEVEL_W = 8;
    // Width of a configuration register index and of its write data.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [LEVEL_W-1:0] t_level;

    // Full-scale level: a pin at this level is never switched off.
    localparam t_level LEVEL_MAX   = 8'hFF;
    localparam t_level LEVEL_ZERO  = 8'h00;
    localparam t_level COUNT_RESET = 8'hFF;
    localparam t_level STEP_RESET  = 8'h01;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FADE_ENABLE  = 3'd0,
        REG_FADE_STEP    = 3'd1,
        REG_TARGET_RED   = 3'd2,
        REG_TARGET_GREEN = 3'd3,
        REG_TARGET_BLUE  = 3'd4
    } t_reg_idx;

    // Per-item control shared by all three channels.
    typedef struct packed {
        logic   load;      // set item: load the level directly
        logic   wrap;      // the counter wraps to zero on this tick
        logic   fade_en;   // fading is enabled
        t_level step;      // largest level change per period
        t_level count;     // period counter after this tick
    } t_tick_ctrl;

endpackage

// File: hw/rtl/rgbpwm_if.sv
// Valid/ready channel interfaces of the RGB soft PWM with fade block.
interface rgbpwm_in_if;
    import rgbpwm_pkg::*;
    logic   valid;
    logic   ready;
    logic   mode;
    t_level new_red;
    t_level new_green;
    t_level new_blue;

    modport source (output valid, output mode, output new_red, output new_green,
                    output new_blue, input ready);
    modport sink   (input valid, input mode, input new_red, input new_green,
                    input new_blue, output ready);
endinterface

interface rgbpwm_out_if;
    import rgbpwm_pkg::*;
    logic   valid;
    logic   ready;
    logic   red_out;
    logic   green_out;
    logic   blue_out;
    t_level red_now;
    t_level green_now;
    t_level blue_now;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output red_now, output green_now, output blue_now, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input red_now, input green_now, input blue_now, output ready);
endinterface

interface rgbpwm_cfg_if;
    import rgbpwm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/rgbpwm_chan.sv
// Next level and next pin state of one PWM channel for one item.
module rgbpwm_chan (
    input  rgbpwm_pkg::t_tick_ctrl i_ctrl,
    input  rgbpwm_pkg::t_level     i_level,
    input  rgbpwm_pkg::t_level     i_target,
    input  rgbpwm_pkg::t_level     i_new_level,
    input  logic                   i_pin,
    output rgbpwm_pkg::t_level     o_level,
    output logic                   o_pin
);
    import rgbpwm_pkg::*;

    logic   above;
    t_level gap;
    t_level delta;
    t_level faded;
    t_level tick_level;
    logic   tick_pin;

    // Move the level toward its target by no more than the step size.
    assign above = i_level > i_target;
    assign gap   = above ? (i_level - i_target) : (i_target - i_level);
    assign delta = (gap < i_ctrl.step) ? gap : i_ctrl.step;
    assign faded = above ? (i_level - delta) : (i_level + delta);

    // At the wrap, a lit level turns the pin on and fading may move the level.
    assign tick_level = (i_ctrl.wrap && i_ctrl.fade_en) ? faded : i_level;
    assign tick_pin   = (i_ctrl.wrap && (i_level != LEVEL_ZERO)) ? 1'b1 : i_pin;

    // A set item replaces the level and leaves the pin; a tick may switch it off.
    always_comb begin
        if (i_ctrl.load) begin
            o_level = i_new_level;
            o_pin   = i_pin;
        end else begin
            o_level = tick_level;
            if ((tick_level != LEVEL_MAX) && (i_ctrl.count == tick_level)) begin
                o_pin = 1'b0;
            end else begin
                o_pin = tick_pin;
            end
        end
    end

endmodule

// File: hw/rtl/rgb_soft_pwm_with_fade_unit.sv
// Top level of the three-channel 8-bit PWM LED driver with linear fade.
//
//  channel | dir | payload
//  --------+-----+------------------------------------------------------------
//  i_in    | in  | mode, new_red, new_green, new_blue
//  o_out   | out | red_out, green_out, blue_out, red_now, green_now, blue_now
//  i_cfg   | in  | index (fade_enable, fade_step_size, target_red/green/blue), data
//
// One item per cycle: an accepted item updates the counter, levels and pins in
// one pass through the channel logic, and the result shows in the next cycle.
// The state registers double as the result register, so a new item is taken
// in the same cycle that the waiting result is taken. Output stall holds the
// input off. Synchronous active-low reset; configuration is always ready.
module rgb_soft_pwm_with_fade_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rgbpwm_in_if.sink    i_in,
    rgbpwm_out_if.source o_out,
    rgbpwm_cfg_if.sink   i_cfg
);
    import rgbpwm_pkg::*;

    // Configuration registers.
    logic   r_fade_en;
    t_level r_step;
    t_level r_target_red;
    t_level r_target_green;
    t_level r_target_blue;

    // Block state; it is also the payload of the result.
    t_level r_count;
    t_level r_red_level;
    t_level r_green_level;
    t_level r_blue_level;
    logic   r_red_pin;
    logic   r_green_pin;
    logic   r_blue_pin;
    logic   r_out_valid;

    t_level     n_count;
    t_level     n_red_level;
    t_level     n_green_level;
    t_level     n_blue_level;
    logic       n_red_pin;
    logic       n_green_pin;
    logic       n_blue_pin;
    t_tick_ctrl tick_ctrl;
    logic       in_accept;

    // Configuration writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_en      <= 1'b0;
            r_step         <= STEP_RESET;
            r_target_red   <= LEVEL_ZERO;
            r_target_green <= LEVEL_ZERO;
            r_target_blue  <= LEVEL_ZERO;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FADE_ENABLE:  r_fade_en      <= i_cfg.data[0];
                REG_FADE_STEP:    r_step         <= i_cfg.data[LEVEL_W-1:0];
                REG_TARGET_RED:   r_target_red   <= i_cfg.data[LEVEL_W-1:0];
                REG_TARGET_GREEN: r_target_green <= i_cfg.data[LEVEL_W-1:0];
                REG_TARGET_BLUE:  r_target_blue  <= i_cfg.data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input handshake: take an item when the result slot is free or draining.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    // Counter advance and per-item control.
    assign n_count = i_in.mode ? r_count : (r_count + t_level'(1));

    assign tick_ctrl.load    = i_in.mode;
    assign tick_ctrl.wrap    = (n_count == LEVEL_ZERO) && !i_in.mode;
    assign tick_ctrl.fade_en = r_fade_en;
    assign tick_ctrl.step    = r_step;
    assign tick_ctrl.count   = n_count;

    rgbpwm_chan u_red (
        .i_ctrl      (tick_ctrl),
        .i_level     (r_red_level),
        .i_target    (r_target_red),
        .i_new_level (i_in.new_red),
        .i_pin       (r_red_pin),
        .o_level     (n_red_level),
        .o_pin       (n_red_pin)
    );

    rgbpwm_chan u_green (
        .i_ctrl      (tick_ctrl),
        .i_level     (r_green_level),
        .i_target    (r_target_green),
        .i_new_level (i_in.new_green),
        .i_pin       (r_green_pin),
        .o_level     (n_green_level),
        .o_pin       (n_green_pin)
    );

    rgbpwm_chan u_blue (
        .i_ctrl      (tick_ctrl),
        .i_level     (r_blue_level),
        .i_target    (r_target_blue),
        .i_new_level (i_in.new_blue),
        .i_pin       (r_blue_pin),
        .o_level     (n_blue_level),
        .o_pin       (n_blue_pin)
    );

    // State and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= COUNT_RESET;
            r_red_level   <= LEVEL_ZERO;
            r_green_level <= LEVEL_ZERO;
            r_blue_level  <= LEVEL_ZERO;
            r_red_pin     <= 1'b0;
            r_green_pin   <= 1'b0;
            r_blue_pin    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_count       <= n_count;
                r_red_level   <= n_red_level;
                r_green_level <= n_green_level;
                r_blue_level  <= n_blue_level;
                r_red_pin     <= n_red_pin;
                r_green_pin   <= n_green_pin;
                r_blue_pin    <= n_blue_pin;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // Result channel.
    assign o_out.valid     = r_out_valid;
    assign o_out.red_out   = r_red_pin;
    assign o_out.green_out = r_green_pin;
    assign o_out.blue_out  = r_blue_pin;
    assign o_out.red_now   = r_red_level;
    assign o_out.green_now = r_green_level;
    assign o_out.blue_now  = r_blue_level;

endmodule
